[rtl/indexed_priority_queue_macros.svh]
// Assertion macros shared by the indexed priority queue checkers.
// Depends on nothing; include it where concurrent assertions are written.
`ifndef INDEXED_PRIORITY_QUEUE_MACROS_SVH
`define INDEXED_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ipq_pkg.sv]
// Package of the indexed priority queue: sizes, operation codes, controller types.
// Depends on nothing; the interfaces, datapath, controller, top level and checker import it.
package ipq_pkg;

  localparam int unsigned NUM_EVENTS = 64;
  localparam int unsigned IDX_W      = $clog2(NUM_EVENTS);
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned PRIO_W     = 31;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } ipq_state_e;

  typedef struct packed {
    logic write;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } ipq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } ipq_stat_t;

endpackage

[rtl/ipq_if.sv]
// Handshake interfaces for the request and result channels of the queue.
// Depends on ipq_pkg for the field widths.
interface ipq_in_if import ipq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   slot_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, operation, slot_id, priority_req, input ready);
  modport sink   (input valid, operation, slot_id, priority_req, output ready);
endinterface

interface ipq_out_if import ipq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] polled_id;

  modport source (output valid, found, polled_id, input ready);
  modport sink   (input valid, found, polled_id, output ready);
endinterface

[rtl/ipq_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ipq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ipq_dp.sv]
// Datapath of the queue: valid bits, priority RAM, scan pipeline, result register.
// Depends on ipq_pkg, ipq_if and ipq_ram.
module ipq_dp import ipq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipq_cmd_t          cmd_i,
  output ipq_stat_t         stat_o,
  input  logic [ID_W-1:0]   slot_id_i,
  input  logic [PRIO_W-1:0] priority_req_i,
  ipq_out_if.source         out_ch
);

  logic [NUM_EVENTS-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]      cnt_q;
  logic                  pv_q;
  logic [IDX_W-1:0]      pidx_q;
  logic                  have_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [PRIO_W-1:0]     best_prio_q;
  logic [PRIO_W-1:0]     rd_prio;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [ID_W-1:0]       out_id_q;
  logic                  id_ok;
  logic [IDX_W-1:0]      widx;
  logic                  take_new;

  assign widx  = slot_id_i[IDX_W-1:0];
  assign id_ok = 32'(slot_id_i) < NUM_EVENTS;

  ipq_ram #(
    .WIDTH (PRIO_W),
    .DEPTH (NUM_EVENTS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && id_ok),
    .waddr_i (widx),
    .wdata_i (priority_req_i),
    .re_i    (cmd_i.scan_step),
    .raddr_i (cnt_q),
    .rdata_o (rd_prio)
  );

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.write && id_ok) begin
      valid_d[widx] = 1'b1;
    end
    if (cmd_i.load_out && have_q) begin
      valid_d[best_idx_q] = 1'b0;
    end
  end

  assign take_new = pv_q && (!have_q || (rd_prio > best_prio_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pv_q    <= cmd_i.scan_step && valid_q[cnt_q];
      if (cmd_i.scan_start) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (take_new) begin
          have_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q;
    if (take_new) begin
      best_idx_q  <= pidx_q;
      best_prio_q <= rd_prio;
    end
    if (cmd_i.load_out) begin
      out_found_q <= have_q;
      out_id_q    <= have_q ? ID_W'(best_idx_q) : '0;
    end
  end

  assign stat_o.scan_last = cnt_q == IDX_W'(NUM_EVENTS - 1);
  assign stat_o.out_busy  = out_valid_q && !out_ch.ready;

  assign out_ch.valid     = out_valid_q;
  assign out_ch.found     = out_found_q;
  assign out_ch.polled_id = out_id_q;

endmodule

[rtl/ipq_ctrl.sv]
// Controller of the queue: accepts requests and sequences the poll scan.
// Depends on ipq_pkg.
module ipq_ctrl import ipq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] operation_i,
  output logic            in_ready_o,
  input  ipq_stat_t       stat_i,
  output ipq_cmd_t        cmd_o
);

  ipq_state_e state_q, state_d;
  logic       is_write;
  logic       is_poll;

  assign is_write = (operation_i == OP_INSERT) || (operation_i == OP_UPDATE);
  assign is_poll  = operation_i == OP_POLL;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && is_poll) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.write      = in_valid_i && is_write;
        cmd_o.scan_start = in_valid_i && is_poll;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RESULT: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/indexed_priority_queue.sv]
// Indexed priority queue: an insert or update is written while the controller is idle; a
// poll result comes from a scan that reads one priority RAM entry per cycle, plus any
// wait for the result register to free. After a poll no new request is accepted until
// its result has been loaded into the result register.
// Reset (rst_ni low, asynchronous) clears all valid bits, the controller and the
// result valid flag; no clearing pass follows reset.
module indexed_priority_queue import ipq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipq_in_if.sink    in_ch,
  ipq_out_if.source out_ch
);

  ipq_cmd_t  cmd;
  ipq_stat_t stat;

  ipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .operation_i (in_ch.operation),
    .in_ready_o  (in_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ipq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .slot_id_i      (in_ch.slot_id),
    .priority_req_i (in_ch.priority_req),
    .out_ch         (out_ch)
  );

endmodule

[rtl/ipq_checker.sv]
// Port-level checker for the indexed priority queue, bound to the top level.
// Depends on ipq_pkg and indexed_priority_queue_macros.svh.
`include "indexed_priority_queue_macros.svh"

module ipq_checker import ipq_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic [OP_W-1:0] operation_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            found_i,
  input logic [ID_W-1:0] polled_id_i
);

  `IPQ_ASSERT_NEXT(a_poll_blocks_input, clk_i, rst_ni, in_valid_i && in_ready_i && operation_i == OP_POLL, !in_ready_i, "input ready after a poll transfer")
  `IPQ_ASSERT_SAME(a_not_found_id_zero, clk_i, rst_ni, out_valid_i && !found_i, polled_id_i == '0, "nonzero id on a not-found result")
  `IPQ_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `IPQ_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(found_i) && $stable(polled_id_i), "result changed while stalled")

endmodule

bind indexed_priority_queue ipq_checker u_ipq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .operation_i (in_ch.operation),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .found_i     (out_ch.found),
  .polled_id_i (out_ch.polled_id)
);

[test/tb_top.sv]
// Self-checking testbench of the indexed priority queue: drives inserts, updates, polls and reserved codes.
// A scoreboard class predicts every poll result and checks the results in order.
// Depends on ipq_pkg, ipq_if.sv and indexed_priority_queue.sv from the RTL.
`timescale 1ns / 1ps

module tb_top;
  import ipq_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] polled_id;
  } poll_result_t;

  class poll_predictor;
    bit                slot_valid[NUM_EVENTS];
    logic [PRIO_W-1:0] slot_prio[NUM_EVENTS];
    poll_result_t      expected_polls[$];
    int                mismatches;

    function new();
      mismatches = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function int pending();
      return expected_polls.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      poll_result_t res;
      bit           have;
      int           best;
      if (op == OP_INSERT || op == OP_UPDATE) begin
        if (id < NUM_EVENTS) begin
          slot_valid[id] = 1'b1;
          slot_prio[id]  = prio;
        end
      end else if (op == OP_POLL) begin
        have = 1'b0;
        best = 0;
        res  = '0;
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if (slot_valid[i] && (!have || slot_prio[i] > slot_prio[best])) begin
            have = 1'b1;
            best = i;
          end
        end
        if (have) begin
          slot_valid[best] = 1'b0;
          res.found        = 1'b1;
          res.polled_id    = ID_W'(best);
        end
        expected_polls.push_back(res);
      end
    endfunction

    function void check_poll(logic found, logic [ID_W-1:0] polled_id);
      poll_result_t exp;
      if (expected_polls.size() == 0) begin
        $display("%0t: unexpected poll result: found=%0d polled_id=%0d",
                 $time, found, polled_id);
        mismatches++;
        return;
      end
      exp = expected_polls.pop_front();
      if (found !== exp.found) begin
        $display("%0t: found expected %0d actual %0d", $time, exp.found, found);
        mismatches++;
      end
      if (polled_id !== exp.polled_id) begin
        $display("%0t: polled_id expected %0d actual %0d", $time, exp.polled_id, polled_id);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ipq_in_if  in_ch ();
  ipq_out_if out_ch ();

  indexed_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poll_predictor predictor = new();
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
    while (in_idle_on && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.slot_id      <= id;
    in_ch.priority_req <= prio;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predictor.note_request(op, id, prio);
    @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (out_idle_on) begin
        out_ch.ready <= ($urandom_range(0, 99) >= 34);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      predictor.check_poll(out_ch.found, out_ch.polled_id);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("indexed_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    int                n;
    int                r;
    int                poll_pct;

    rst_ni             = 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_INSERT;
    in_ch.slot_id      <= '0;
    in_ch.priority_req <= '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // An empty table, a reserved code, then ties, overwrites and an update of an absent slot.
    send_request(OP_POLL, '0, '0);
    send_request(OP_RESERVED, 6'h3F, PRIO_MAX);
    send_request(OP_POLL, 6'h3F, PRIO_MAX);
    send_request(OP_INSERT, 6'd0, '0);
    send_request(OP_INSERT, 6'd63, PRIO_MAX);
    send_request(OP_INSERT, 6'd5, PRIO_MAX);
    send_request(OP_UPDATE, 6'd10, 31'd7);
    send_request(OP_INSERT, 6'd0, 31'd7);
    send_request(OP_INSERT, 6'h2A, 31'h2AAAAAAA);
    send_request(OP_UPDATE, 6'h15, 31'h55555555);
    send_request(OP_UPDATE, 6'h2A, 31'h55555555);
    send_request(OP_RESERVED, 6'h15, 31'h2AAAAAAA);
    repeat (7) send_request(OP_POLL, '0, '0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      in_idle_on  = !(n >= 300 && n < 450);
      out_idle_on = in_idle_on;
      if (n == 500) hold_req = 1'b1;
      if (n == 650) begin
        while (predictor.pending() != 0) begin
          in_ch.valid <= 1'b0;
          @(negedge clk_i);
        end
      end
      poll_pct = ((n / 100) % 2 == 0) ? 25 : 60;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_RESERVED;
      end else if (r < 3 + poll_pct) begin
        op = OP_POLL;
      end else begin
        op = $urandom_range(0, 1) ? OP_UPDATE : OP_INSERT;
      end
      id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 63)) : ID_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: prio = PRIO_W'($urandom);
        1: prio = PRIO_W'($urandom_range(0, 3));
        2: prio = PRIO_MAX - PRIO_W'($urandom_range(0, 1));
        default: prio = PRIO_W'($urandom_range(0, 255));
      endcase
      send_request(op, id, prio);
      if (op != OP_RESERVED) n++;
    end
    in_ch.valid <= 1'b0;

    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (NUM_EVENTS + 8) @(posedge clk_i);
    if (predictor.mismatches == 0) begin
      $display("indexed_priority_queue: match");
    end else begin
      $display("indexed_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
